@@ sv/whs_pkg.sv @@
// Shared types, constants and CORDIC helpers for the wave height block.
`timescale 1ns / 1ps
package whs_pkg;

  localparam int unsigned MAX_COMPONENTS_DEF = 128;

  localparam int unsigned FREQ_W  = 24;
  localparam int unsigned DIR_W   = 16;
  localparam int unsigned AMP_W   = 24;
  localparam int unsigned PHASE_W = 16;
  localparam int unsigned POS_W   = 32;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned IG_W    = 24;
  localparam int unsigned ACT_W   = 8;
  localparam int unsigned CFG_W   = 24;
  localparam int unsigned RAM_W   = FREQ_W + DIR_W + AMP_W + PHASE_W;
  localparam int unsigned IN_W    = 184;
  localparam int unsigned OUT_W   = 32;

  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned CRD_W        = 34;
  localparam int unsigned TERM_W       = 39;
  localparam int unsigned PIPE_LEN     = 39;

  localparam logic [IG_W-1:0] IG_RESET     = 24'd1710216;
  localparam logic [29:0]     INV_TWO_PI   = 30'd683565276;
  localparam logic signed [CRD_W-1:0] CORDIC_GAIN = 34'sd652032874;

  // Register indexes on the configuration port
  typedef enum logic [0:0] {
    REG_ACTIVE      = 1'b0,
    REG_INV_GRAVITY = 1'b1
  } reg_idx_e;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_EVAL = 1'b1;

  typedef struct packed {
    logic valid;
    logic last;
  } issue_t;

  typedef struct packed {
    logic                     valid;
    logic                     last;
    logic signed [TERM_W-1:0] term;
  } term_t;

  typedef struct packed {
    logic                    flip;
    logic signed [CRD_W-1:0] x;
    logic signed [CRD_W-1:0] y;
    logic signed [CRD_W-1:0] z;
  } cordic_t;

  // atan(2^-i) in Q0.32 turns
  function automatic logic signed [CRD_W-1:0] turn_atan(input int unsigned i);
    logic signed [CRD_W-1:0] r;
    case (i)
      0:       r = 34'sh020000000;
      1:       r = 34'sh012E4051D;
      2:       r = 34'sh009FB385B;
      3:       r = 34'sh0051111D4;
      4:       r = 34'sh0028B0D43;
      5:       r = 34'sh00145D7E1;
      6:       r = 34'sh000A2F61E;
      7:       r = 34'sh000517C55;
      8:       r = 34'sh00028BE53;
      9:       r = 34'sh000145F2E;
      10:      r = 34'sh0000A2F98;
      11:      r = 34'sh0000517CC;
      12:      r = 34'sh000028BE6;
      13:      r = 34'sh0000145F3;
      14:      r = 34'sh00000A2F9;
      15:      r = 34'sh00000517C;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Fold the angle into the right half plane and seed the rotation
  function automatic cordic_t cordic_init(input logic [31:0] ang);
    cordic_t     r;
    logic [31:0] q;
    logic [31:0] a;
    q      = ang + 32'h4000_0000;
    a      = q[31] ? (ang - 32'h8000_0000) : ang;
    r.flip = q[31];
    r.x    = CORDIC_GAIN;
    r.y    = '0;
    r.z    = {{2{a[31]}}, a};
    return r;
  endfunction

  function automatic cordic_t cordic_step(input cordic_t c, input int unsigned i);
    cordic_t                 r;
    logic signed [CRD_W-1:0] xs;
    logic signed [CRD_W-1:0] ys;
    xs     = c.x >>> i;
    ys     = c.y >>> i;
    r.flip = c.flip;
    if (!c.z[CRD_W-1]) begin
      r.x = c.x - ys;
      r.y = c.y + xs;
      r.z = c.z - turn_atan(i);
    end else begin
      r.x = c.x + ys;
      r.y = c.y - xs;
      r.z = c.z + turn_atan(i);
    end
    return r;
  endfunction

endpackage

@@ sv/whs_ram.sv @@
// Generic single-port-write RAM with registered read.
`timescale 1ns / 1ps
module whs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/whs_term_pipe.sv @@
// Per-component pipeline: wavenumber, two CORDICs and the weighted cosine term.
`timescale 1ns / 1ps
module whs_term_pipe (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  whs_pkg::issue_t                     iss_i,
  input  logic [whs_pkg::FREQ_W-1:0]          freq_i,
  input  logic [whs_pkg::DIR_W-1:0]           dir_i,
  input  logic [whs_pkg::AMP_W-1:0]           amp_i,
  input  logic [whs_pkg::PHASE_W-1:0]         phase_i,
  input  logic signed [whs_pkg::POS_W-1:0]    pos_x_i,
  input  logic signed [whs_pkg::POS_W-1:0]    pos_y_i,
  input  logic [whs_pkg::TIME_W-1:0]          time_i,
  input  logic [whs_pkg::IG_W-1:0]            inv_g_i,
  output whs_pkg::term_t                      term_o
);

  localparam int unsigned NS = whs_pkg::CORDIC_STEPS;
  localparam int unsigned PL = whs_pkg::PIPE_LEN;

  typedef struct packed {
    logic                          last;
    logic [whs_pkg::AMP_W-1:0]     amp;
    logic [whs_pkg::PHASE_W-1:0]   phase;
    logic [37:0]                   kt;
    logic [31:0]                   tm;
  } side_t;

  logic [PL:1]      vld_q;
  side_t            side_q [1:PL];
  whs_pkg::cordic_t c1_q [NS+1];
  whs_pkg::cordic_t c2_q [NS+1];

  logic [47:0]        ww_q;
  logic [33:0]        wt_q;
  logic [31:0]        k_q;
  logic [49:0]        wtl_q;
  logic [47:0]        wth_q;
  logic signed [65:0] pcx_q;
  logic signed [65:0] psy_q;
  logic signed [34:0] d_q;
  logic signed [59:0] pl_q;
  logic signed [49:0] phh_q;
  logic [31:0]        ang_q;
  logic signed [58:0] prod_q;

  logic [55:0]        prod_kg;
  logic [61:0]        prod_kc;
  logic [53:0]        prod_wc;
  logic [47:0]        tm48;
  logic signed [33:0] cd;
  logic signed [33:0] sd;
  logic signed [33:0] cp;
  logic signed [66:0] dsum;
  logic [47:0]        sp48;

  assign prod_kg = ww_q[47:16] * inv_g_i;
  assign prod_kc = k_q * whs_pkg::INV_TWO_PI;
  assign prod_wc = freq_i * whs_pkg::INV_TWO_PI;
  assign tm48    = wtl_q[47:0] + {wth_q[29:0], 18'h0};
  assign cd      = c1_q[NS].flip ? -c1_q[NS].x : c1_q[NS].x;
  assign sd      = c1_q[NS].flip ? -c1_q[NS].y : c1_q[NS].y;
  assign cp      = c2_q[NS].flip ? -c2_q[NS].x : c2_q[NS].x;
  assign dsum    = 67'(pcx_q) + 67'(psy_q);
  assign sp48    = pl_q[47:0] + {phh_q[23:0], 24'h0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[PL-1:1], iss_i.valid};
    end
  end

  // Front stages: squares, products and direction CORDIC seed
  always_ff @(posedge clk_i) begin
    side_q[1] <= '{last: iss_i.last, amp: amp_i, phase: phase_i, kt: '0, tm: '0};
    ww_q      <= freq_i * freq_i;
    wt_q      <= prod_wc[53:20];
    c1_q[0]   <= whs_pkg::cordic_init({dir_i, 16'h0});

    side_q[2] <= side_q[1];
    k_q       <= prod_kg[55:24];
    wtl_q     <= wt_q[17:0] * time_i;
    wth_q     <= wt_q[33:18] * time_i;

    side_q[3] <= '{last: side_q[2].last, amp: side_q[2].amp, phase: side_q[2].phase,
                   kt: prod_kc[61:24], tm: tm48[47:16]};

    pcx_q <= cd * pos_x_i;
    psy_q <= sd * pos_y_i;
    d_q   <= dsum[64:30];
    pl_q  <= $signed({1'b0, side_q[19].kt[23:0]}) * d_q;
    phh_q <= $signed({1'b0, side_q[19].kt[37:24]}) * d_q;
    ang_q <= sp48[47:16] - side_q[20].tm + {side_q[20].phase, 16'h0};
    c2_q[0] <= whs_pkg::cordic_init(ang_q);
    prod_q  <= $signed({1'b0, side_q[PL-1].amp}) * cp;
  end

  for (genvar s = 4; s <= PL; s++) begin : g_side
    always_ff @(posedge clk_i) begin
      side_q[s] <= side_q[s-1];
    end
  end

  for (genvar j = 0; j < NS; j++) begin : g_cordic
    always_ff @(posedge clk_i) begin
      c1_q[j+1] <= whs_pkg::cordic_step(c1_q[j], j);
      c2_q[j+1] <= whs_pkg::cordic_step(c2_q[j], j);
    end
  end

  assign term_o.valid = vld_q[PL];
  assign term_o.last  = side_q[PL].last;
  assign term_o.term  = prod_q[58:20];

endmodule

@@ sv/wave_height_superposition_core.sv @@
// Top level: component table, evaluation sequencer, accumulator and output register.
`timescale 1ns / 1ps
// Ocean surface height as a sum of sinusoidal wave components.
// Input stream (s_axis): tuser selects the function; a load transaction writes
// one component slot, an evaluate transaction gives a point and a time.
// Output stream (m_axis): one height per evaluate transaction, none per load.
// Configuration: cfg_we_i writes register cfg_idx_i (0 active count,
// 1 inverse gravity) at the clock edge; write only while the block is idle.
// A load writes its table slot without leaving idle. An evaluate with n
// components (the active count capped at MAX_COMPONENTS) reads the table
// once per component, one per cycle, into a 39-stage term pipeline (two
// 16-step CORDICs plus multipliers) whose outputs are summed in one
// accumulator. After the last term, or straight away when n is 0, the
// height goes to the output register once it is free, and the block
// returns to idle.
// One item is in work at a time; s_axis_tready is high only while idle.
// The result sits in an output register, so the next transaction is taken
// while a result still waits; if the receiver stalls, the next result holds
// in the accumulator until the register frees.
// Reset clears control state and the registers (active count 0, inverse
// gravity 1/9.81); table contents stay undefined until loaded.
module wave_height_superposition_core #(
  parameter int unsigned MAX_COMPONENTS = whs_pkg::MAX_COMPONENTS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // slot[6:0] ang_freq[30:7] direction[46:31] amplitude[70:47]
  // start_phase[86:71] pos_x[118:87] pos_y[150:119] time_s[182:151], pad
  input  logic [whs_pkg::IN_W-1:0]      s_axis_tdata,
  // func[0]
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // height[31:0]
  output logic [whs_pkg::OUT_W-1:0]     m_axis_tdata,
  input  logic                          cfg_we_i,
  input  logic [0:0]                    cfg_idx_i,
  input  logic [whs_pkg::CFG_W-1:0]     cfg_wdata_i
);

  localparam int unsigned AW    = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_COMPONENTS + 1);
  localparam int unsigned ACC_W = whs_pkg::TERM_W + CNT_W + 1;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_RUN   = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [whs_pkg::ACT_W-1:0] active_q;
  logic [whs_pkg::IG_W-1:0]  inv_g_q;
  logic [AW-1:0]             cnt_q, cnt_d;
  logic [CNT_W-1:0]          n_q, n_d;
  logic signed [ACC_W-1:0]   acc_q, acc_d;
  logic signed [whs_pkg::POS_W-1:0] pos_x_q, pos_y_q;
  logic [whs_pkg::TIME_W-1:0] time_q;
  whs_pkg::issue_t           iss_q, iss_d;
  logic                      out_vld_q, out_vld_d;
  logic [whs_pkg::OUT_W-1:0] out_q, out_d;

  logic                      in_fire;
  logic                      is_eval;
  logic                      ram_we;
  logic [whs_pkg::RAM_W-1:0] ram_wdata;
  logic [whs_pkg::RAM_W-1:0] ram_rdata;
  logic [CNT_W-1:0]          n_cap;
  logic                      issue_last;
  logic                      out_free;
  whs_pkg::term_t            term;
  logic signed [ACC_W-1:0]   h_sum;
  logic signed [ACC_W-1:0]   h_val;
  logic [whs_pkg::OUT_W-1:0] h_sat;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign is_eval       = (s_axis_tuser == whs_pkg::FUNC_EVAL);

  // Loads beyond the table are dropped
  assign ram_we    = in_fire && !is_eval && (32'(s_axis_tdata[6:0]) < 32'(MAX_COMPONENTS));
  assign ram_wdata = {s_axis_tdata[86:71], s_axis_tdata[70:47],
                      s_axis_tdata[46:31], s_axis_tdata[30:7]};

  assign n_cap = (32'(active_q) > 32'(MAX_COMPONENTS)) ? CNT_W'(MAX_COMPONENTS)
                                                      : CNT_W'(active_q);
  assign issue_last = (CNT_W'(cnt_q) + CNT_W'(1)) == n_q;
  assign out_free   = !out_vld_q || m_axis_tready;

  whs_ram #(
    .WIDTH (whs_pkg::RAM_W),
    .DEPTH (MAX_COMPONENTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(s_axis_tdata[6:0])),
    .wdata_i (ram_wdata),
    .raddr_i (cnt_q),
    .rdata_o (ram_rdata)
  );

  whs_term_pipe u_pipe (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .iss_i   (iss_q),
    .freq_i  (ram_rdata[23:0]),
    .dir_i   (ram_rdata[39:24]),
    .amp_i   (ram_rdata[63:40]),
    .phase_i (ram_rdata[79:64]),
    .pos_x_i (pos_x_q),
    .pos_y_i (pos_y_q),
    .time_i  (time_q),
    .inv_g_i (inv_g_q),
    .term_o  (term)
  );

  // Round to Q16.16 and clamp to the 32-bit range
  assign h_sum = acc_q + ACC_W'(8192);
  assign h_val = h_sum >>> 14;
  always_comb begin
    if (&h_val[ACC_W-1:31] || ~|h_val[ACC_W-1:31]) begin
      h_sat = h_val[31:0];
    end else if (h_val[ACC_W-1]) begin
      h_sat = 32'h8000_0000;
    end else begin
      h_sat = 32'h7FFF_FFFF;
    end
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    n_d       = n_q;
    acc_d     = acc_q;
    iss_d     = '0;
    out_vld_d = out_vld_q && !m_axis_tready;
    out_d     = out_q;

    if (term.valid) begin
      acc_d = acc_q + ACC_W'(term.term);
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire && is_eval) begin
          cnt_d   = '0;
          n_d     = n_cap;
          acc_d   = '0;
          state_d = (n_cap == '0) ? ST_DONE : ST_RUN;
        end
      end
      ST_RUN: begin
        // Issue one table read per cycle
        iss_d.valid = 1'b1;
        iss_d.last  = issue_last;
        cnt_d       = cnt_q + AW'(1);
        if (issue_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (term.valid && term.last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // Hold until the output register frees
        if (out_free) begin
          out_vld_d = 1'b1;
          out_d     = h_sat;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      n_q       <= '0;
      iss_q     <= '0;
      out_vld_q <= 1'b0;
      active_q  <= '0;
      inv_g_q   <= whs_pkg::IG_RESET;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      n_q       <= n_d;
      iss_q     <= iss_d;
      out_vld_q <= out_vld_d;
      if (cfg_we_i) begin
        case (whs_pkg::reg_idx_e'(cfg_idx_i))
          whs_pkg::REG_ACTIVE:      active_q <= cfg_wdata_i[whs_pkg::ACT_W-1:0];
          whs_pkg::REG_INV_GRAVITY: inv_g_q  <= cfg_wdata_i[whs_pkg::IG_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    out_q <= out_d;
    if (in_fire && is_eval) begin
      pos_x_q <= s_axis_tdata[118:87];
      pos_y_q <= s_axis_tdata[150:119];
      time_q  <= s_axis_tdata[182:151];
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

`ifndef SYNTHESIS
  a_term_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    term.valid |-> (state_q == ST_RUN || state_q == ST_DRAIN))
    else $error("pipeline term outside an evaluation");

  a_run_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (CNT_W'(cnt_q) < n_q))
    else $error("issue counter past active count");

  a_run_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |=> (state_q == ST_RUN || state_q == ST_DRAIN))
    else $error("illegal exit from issue phase");

  a_done_delivers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_free) |=> (m_axis_tvalid && state_q == ST_IDLE))
    else $error("finished evaluation did not reach the output register");
`endif

endmodule

@@ tb/wave_height_checker.sv @@
// Checker for the wave height block: watches all ports, predicts heights and compares.
`timescale 1ns / 1ps
module wave_height_checker
  import whs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  input  logic              s_axis_tready,
  input  logic [IN_W-1:0]   s_axis_tdata,
  input  logic              s_axis_tuser,
  input  logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  input  logic [OUT_W-1:0]  m_axis_tdata,
  input  logic              cfg_we_i,
  input  logic [0:0]        cfg_idx_i,
  input  logic [CFG_W-1:0]  cfg_wdata_i,
  output int                errors_o,
  output int                pending_o
);

  localparam longint TURN_ATAN [CORDIC_STEPS] = '{
    64'h20000000, 64'h12E4051D, 64'h09FB385B, 64'h051111D4,
    64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
    64'h0028BE53, 64'h00145F2E, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2F9, 64'h0000517C
  };
  localparam logic [63:0] INV_2PI = 64'd683565276;

  logic [FREQ_W-1:0]  freq_tab  [MAX_COMPONENTS_DEF];
  logic [DIR_W-1:0]   dir_tab   [MAX_COMPONENTS_DEF];
  logic [AMP_W-1:0]   amp_tab   [MAX_COMPONENTS_DEF];
  logic [PHASE_W-1:0] phase_tab [MAX_COMPONENTS_DEF];
  logic [ACT_W-1:0]   active_cnt;
  logic [IG_W-1:0]    inv_grav;
  // ring of predicted heights, oldest at rd_cnt
  logic [OUT_W-1:0]   exp_heights [64];
  int                 wr_cnt;
  int                 rd_cnt;

  assign pending_o = wr_cnt - rd_cnt;

  // cos and sin of a Q0.32 turn angle, Q2.30 results
  function automatic void turn_cos_sin(input logic [31:0] ang, output longint c,
                                       output longint s);
    logic [31:0] q;
    logic [31:0] a;
    logic        flip;
    longint      x, y, z, xs, ys;
    q    = ang + 32'h4000_0000;
    flip = q[31];
    a    = flip ? ang - 32'h8000_0000 : ang;
    x    = 652032874;
    y    = 0;
    z    = longint'(signed'(a));
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - TURN_ATAN[i];
      end else begin
        x = x + ys; y = y - xs; z = z + TURN_ATAN[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic logic [OUT_W-1:0] surface_height(input logic [IN_W-1:0] d);
    longint      px, py, acc, cd, sd, cp, sp, proj, h;
    logic [63:0] w, k, kt, wt, t, sprod, tprod;
    logic [31:0] ang;
    int          n;
    px  = longint'(signed'(d[118:87]));
    py  = longint'(signed'(d[150:119]));
    t   = {32'd0, d[182:151]};
    n   = (active_cnt > MAX_COMPONENTS_DEF) ? MAX_COMPONENTS_DEF : active_cnt;
    acc = 0;
    for (int i = 0; i < n; i++) begin
      w     = {40'd0, freq_tab[i]};
      k     = (((w * w) >> 16) * {40'd0, inv_grav}) >> 24;
      kt    = (k * INV_2PI) >> 24;
      wt    = (w * INV_2PI) >> 20;
      turn_cos_sin({dir_tab[i], 16'd0}, cd, sd);
      proj  = (cd * px + sd * py) >>> 30;
      sprod = kt * 64'(proj);
      tprod = wt * t;
      ang   = sprod[47:16] - tprod[47:16] + {phase_tab[i], 16'd0};
      turn_cos_sin(ang, cp, sp);
      acc   = acc + ((longint'({40'd0, amp_tab[i]}) * cp) >>> 20);
    end
    h = (acc + 8192) >>> 14;
    if (h > 64'sd2147483647) h = 64'sd2147483647;
    if (h < -64'sd2147483648) h = -64'sd2147483648;
    return h[31:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_cnt <= '0;
      inv_grav   <= IG_RESET;
      errors_o   <= 0;
      wr_cnt     <= 0;
      rd_cnt     <= 0;
    end else begin
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_idx_i))
          REG_ACTIVE:      active_cnt <= cfg_wdata_i[ACT_W-1:0];
          REG_INV_GRAVITY: inv_grav   <= cfg_wdata_i[IG_W-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == FUNC_LOAD) begin
          freq_tab[s_axis_tdata[6:0]]  <= s_axis_tdata[30:7];
          dir_tab[s_axis_tdata[6:0]]   <= s_axis_tdata[46:31];
          amp_tab[s_axis_tdata[6:0]]   <= s_axis_tdata[70:47];
          phase_tab[s_axis_tdata[6:0]] <= s_axis_tdata[86:71];
        end else begin
          exp_heights[6'(wr_cnt)] <= surface_height(s_axis_tdata);
          wr_cnt                  <= wr_cnt + 1;
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (wr_cnt == rd_cnt) begin
          $error("height: unexpected result %0d", $signed(m_axis_tdata));
          errors_o <= errors_o + 1;
        end else if (exp_heights[6'(rd_cnt)] !== m_axis_tdata) begin
          $error("height: expected %0d, got %0d", $signed(exp_heights[6'(rd_cnt)]),
                 $signed(m_axis_tdata));
          errors_o <= errors_o + 1;
          rd_cnt   <= rd_cnt + 1;
        end else begin
          rd_cnt   <= rd_cnt + 1;
        end
      end
    end
  end

endmodule

@@ tb/testbench.sv @@
// Top of the wave height testbench: clock, reset, stimulus, result sink and verdict.
`timescale 1ns / 1ps
module testbench;
  import whs_pkg::*;

  logic              clk_i;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [IN_W-1:0]   s_axis_tdata;   // slot, ang_freq, direction, amplitude,
                                     // start_phase, pos_x, pos_y, time_s, pad
  logic              s_axis_tuser;   // func
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [OUT_W-1:0]  m_axis_tdata;   // height
  logic              cfg_we_i;
  logic [0:0]        cfg_idx_i;
  logic [CFG_W-1:0]  cfg_wdata_i;
  int                fail_cnt;
  int                height_pending;
  int                heights_taken;
  logic              idle_free;      // burst stretch: sender never idles

  wave_height_superposition_core DUT (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
  );

  wave_height_checker checker_i (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .errors_o(fail_cnt), .pending_o(height_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #60ms;
    $display("testbench: errors");
    $finish;
  end

  // Offer one transaction; idle for a random gap, possibly none, unless in a burst stretch
  task automatic send_item(input logic fn, input logic [6:0] slot, input logic [23:0] freq,
                           input logic [15:0] dir, input logic [23:0] amp,
                           input logic [15:0] ph, input logic [31:0] px,
                           input logic [31:0] py, input logic [31:0] tm);
    int gap;
    gap = idle_free ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tuser  = fn;
    s_axis_tdata  = {1'b0, tm, py, px, ph, amp, dir, freq, slot};
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic load_rand(input logic [6:0] slot);
    send_item(FUNC_LOAD, slot, 24'($urandom), 16'($urandom), 24'($urandom),
              16'($urandom), 0, 0, 0);
  endtask

  task automatic eval_rand();
    send_item(FUNC_EVAL, 7'($urandom), 0, 0, 0, 0, $urandom, $urandom, $urandom);
  endtask

  // Drain all heights, let a trailing load settle, then write one register
  task automatic write_reg(input reg_idx_e idx, input logic [CFG_W-1:0] val);
    s_axis_tvalid = 1'b0;
    while (height_pending != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
    cfg_idx_i   = idx;
    cfg_wdata_i = val;
    cfg_we_i    = 1'b1;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
  endtask

  // Result sink: random stalls, recurring zero-stall stretches and one long hold-off
  initial begin
    int w;
    m_axis_tready = 1'b0;
    heights_taken = 0;
    @(posedge rst_ni);
    forever begin
      w = ((heights_taken / 40) % 4 == 1) ? 0 : $urandom_range(0, 17);
      if (w > 0) begin
        m_axis_tready = 1'b0;
        repeat (w) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      @(negedge clk_i);
      heights_taken++;
      if (heights_taken == 60) begin
        // hold off long enough for the block to back up into its input
        m_axis_tready = 1'b0;
        repeat (3000) @(negedge clk_i);
      end
    end
  end

  initial begin
    logic [CFG_W-1:0] act_set [6];
    logic [CFG_W-1:0] ig_set  [6];
    s_axis_tvalid = 1'b0;
    s_axis_tuser  = FUNC_LOAD;
    s_axis_tdata  = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_ACTIVE;
    cfg_wdata_i   = '0;
    idle_free     = 1'b0;
    rst_ni = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: empty sum at reset, then a few slots at their extremes
    send_item(FUNC_EVAL, 0, 0, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    send_item(FUNC_EVAL, 0, 0, 0, 0, 0, 0, 0, 0);
    send_item(FUNC_LOAD, 0, 0, 0, 0, 0, 0, 0, 0);
    send_item(FUNC_LOAD, 1, 24'hFF_FFFF, 16'h4000, 24'hFF_FFFF, 16'hFFFF, 0, 0, 0);
    send_item(FUNC_LOAD, 2, 24'h10_0000, 16'h8000, 24'h10_0000, 16'h0000, 0, 0, 0);
    send_item(FUNC_LOAD, 3, 24'h00_0001, 16'hC000, 24'hFF_FFFF, 16'h8000, 0, 0, 0);
    send_item(FUNC_LOAD, 127, 24'hFF_FFFF, 16'hFFFF, 24'hFF_FFFF, 16'hFFFF, 0, 0, 0);
    write_reg(REG_ACTIVE, 4);
    send_item(FUNC_EVAL, 0, 0, 0, 0, 0, 0, 0, 0);
    send_item(FUNC_EVAL, 0, 0, 0, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_item(FUNC_EVAL, 0, 0, 0, 0, 0, 32'h8000_0000, 32'h8000_0000, 32'h0001_0000);
    send_item(FUNC_EVAL, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000);
    write_reg(REG_INV_GRAVITY, 24'hFF_FFFF);
    send_item(FUNC_EVAL, 0, 0, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678);
    write_reg(REG_INV_GRAVITY, 0);
    send_item(FUNC_EVAL, 0, 0, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678);

    // Fill the whole table so any active count reads written slots only
    for (int i = 0; i < MAX_COMPONENTS_DEF; i++) load_rand(7'(i));

    act_set = '{128, 1, 255, 24'($urandom_range(0, 128)), 0, 128};
    ig_set  = '{IG_RESET, 0, 24'hFF_FFFF, 24'($urandom), 24'($urandom), IG_RESET};
    for (int p = 0; p < 6; p++) begin
      write_reg(REG_ACTIVE, act_set[p]);
      write_reg(REG_INV_GRAVITY, ig_set[p]);
      for (int j = 0; j < 300; j++) begin
        idle_free = (j < 40) && p[0];
        if ($urandom_range(0, 9) < 3) load_rand(7'($urandom));
        else eval_rand();
      end
      idle_free = 1'b0;
    end
    s_axis_tvalid = 1'b0;

    while (height_pending != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
    if (fail_cnt == 0 && height_pending == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/whs_pkg.sv
sv/whs_ram.sv
sv/whs_term_pipe.sv
sv/wave_height_superposition_core.sv
tb/wave_height_checker.sv
tb/testbench.sv
